>>> rtl/core/dlpm_pkg.sv
// Shared types and constants for the DFA longest-prefix matcher.
// Depends on nothing; dlpm_front, dlpm_back and the top level import it.
package dlpm_pkg;

  localparam int NUM_STATES_DEF    = 256;
  localparam int ALPHABET_SIZE_DEF = 128;
  localparam int LENGTH_BITS_DEF   = 16;

  localparam int FRONT_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH   = 4;

  localparam int SIU_W   = 9;
  localparam int STATE_W = 8;
  localparam int CHAR_W  = 7;
  localparam int LEN_W   = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MARK  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_SRC  = 3'd2,
    ST_BAD_DST  = 3'd3,
    ST_DUP      = 3'd4
  } status_t;

  typedef enum logic {
    RK_STATUS = 1'b0,
    RK_MATCH  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [STATE_W-1:0] source_state;
    logic [CHAR_W-1:0]  character;
    logic [STATE_W-1:0] dest_state;
    logic               is_last;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [2:0]       status;
    logic [LEN_W-1:0] match_length;
    logic             accepted;
  } out_item_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] src;
    logic [CHAR_W-1:0]  ch;
    logic [STATE_W-1:0] dst;
    logic               last;
    logic               badch;
  } cmd_t;

endpackage

>>> rtl/core/dlpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module dlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

>>> rtl/core/dlpm_fifo.sv
// Small flop-based queue with valid/ready on both sides and an occupancy count.
// Depends on nothing; DEPTH must be at least 2.
module dlpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_valid,
  output logic                       push_ready,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       pop_valid,
  input  logic                       pop_ready,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[head_r];
  assign count      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[tail_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/dlpm_front.sv
// Front end: accept input items, classify them and queue them for the back end.
// Depends on dlpm_pkg and dlpm_fifo.
module dlpm_front #(
  parameter int ALPHABET_SIZE = dlpm_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clearing,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlpm_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output dlpm_pkg::cmd_t      q_cmd
);

  import dlpm_pkg::*;

  cmd_t                           cmd;
  logic                           push_ready;
  logic                           push_valid;
  logic [$clog2(FRONT_Q_DEPTH+1)-1:0] q_count;

  always_comb begin
    cmd.op    = op_t'(in_item.operation);
    cmd.src   = in_item.source_state;
    cmd.ch    = in_item.character;
    cmd.dst   = in_item.dest_state;
    cmd.last  = in_item.is_last;
    cmd.badch = (in_item.character == '0) || (32'(in_item.character) >= ALPHABET_SIZE);
  end

  // Hold off input during the table clearing pass; drop unused opcodes here
  assign in_ready   = !clearing && push_ready;
  assign push_valid = in_valid && !clearing && (cmd.op != OP_NONE);

  dlpm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (FRONT_Q_DEPTH)
  ) u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd),
    .count      (q_count)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == '0) |-> !q_valid)
    else $error("command queue shows valid while empty");

endmodule

>>> rtl/core/dlpm_back.sv
// Back end: table and accepting-flag memories, clearing pass, scan pipeline
// and result queue. Depends on dlpm_pkg, dlpm_ram and dlpm_fifo.
module dlpm_back #(
  parameter int NUM_STATES    = dlpm_pkg::NUM_STATES_DEF,
  parameter int ALPHABET_SIZE = dlpm_pkg::ALPHABET_SIZE_DEF,
  parameter int LENGTH_BITS   = dlpm_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dlpm_pkg::SIU_W-1:0] states_in_use,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  dlpm_pkg::cmd_t             q_cmd,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dlpm_pkg::out_item_t        out_item
);

  import dlpm_pkg::*;

  localparam int TD  = NUM_STATES * ALPHABET_SIZE;
  localparam int TAW = $clog2(TD);
  localparam int SAW = $clog2(NUM_STATES);
  localparam int TW  = STATE_W + 1;
  localparam int LB  = LENGTH_BITS;
  localparam int OCW = $clog2(OUT_Q_DEPTH + 1);

  function automatic logic st_ok(input logic [STATE_W-1:0] s,
                                 input logic [SIU_W-1:0]   siu);
    st_ok = ({1'b0, s} < siu) && (32'(s) < NUM_STATES);
  endfunction

  // clearing pass
  logic           clearing_r, clearing_nxt;
  logic [TAW-1:0] clr_addr_r, clr_addr_nxt;

  // scan state
  logic [STATE_W-1:0] dfa_state_r, dfa_state_nxt;
  logic               dead_r, dead_nxt;
  logic [LB-1:0]      chars_r, chars_nxt, chars_inc;
  logic [LB-1:0]      best_r, best_nxt, best_new;
  logic               seen_r, seen_nxt, seen_new;

  // stage 2: table data arrives
  logic           issue;
  logic           e2_v_r;
  cmd_t           e2_cmd_r;
  logic [TAW-1:0] e2_addr_r;
  logic [STATE_W-1:0] rd_state;
  logic [TAW-1:0] rd_addr;

  // stage 3: accepting flag arrives, result formed
  logic          e3_v_r;
  logic          e3_has_r, e3_has_nxt;
  kind_t         e3_kind_r, e3_kind_nxt;
  status_t       e3_status_r, e3_status_nxt;
  logic          e3_took_r, e3_took_nxt;
  logic          e3_emit_r, e3_emit_nxt;
  logic [LB-1:0] e3_chars_r, e3_chars_nxt;

  // memory ports
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr;
  logic [TW-1:0]  tbl_wdata;
  logic [TW-1:0]  tbl_rdata;
  logic           acc_we;
  logic [SAW-1:0] acc_waddr;
  logic           acc_wdata;
  logic [SAW-1:0] acc_raddr;
  logic           acc_rdata;

  // result queue
  logic      oq_push, oq_push_ready;
  out_item_t oq_data;
  logic [OCW-1:0] oq_count;
  logic      e2_wr_hold;
  logic      credit_ok;

  assign clearing = clearing_r;

  // A transition write reads, checks and writes the same entry: hold off issue while it is in stage 2
  assign e2_wr_hold = e2_v_r && (e2_cmd_r.op == OP_WRITE);
  // Issue only with room for every item in flight in the result queue
  assign credit_ok  = (32'(oq_count) + 32'(e2_v_r) + 32'(e3_v_r)) < OUT_Q_DEPTH;
  assign q_ready    = !clearing_r && !e2_wr_hold && credit_ok;
  assign issue      = q_valid && q_ready;

  // A scan addresses the table with the state the previous scan leaves
  always_comb begin
    rd_state = (q_cmd.op == OP_SCAN) ? dfa_state_nxt : q_cmd.src;
    rd_addr  = TAW'(rd_state) * TAW'(ALPHABET_SIZE) + TAW'(q_cmd.ch);
  end

  assign chars_inc = (chars_r == '1) ? chars_r : chars_r + 1'b1;
  assign acc_raddr = SAW'(tbl_rdata[STATE_W-1:0]);

  // stage 2
  always_comb begin
    clearing_nxt  = clearing_r;
    clr_addr_nxt  = clr_addr_r;
    dfa_state_nxt = dfa_state_r;
    dead_nxt      = dead_r;
    chars_nxt     = chars_r;
    tbl_we        = 1'b0;
    tbl_waddr     = e2_addr_r;
    tbl_wdata     = {1'b1, e2_cmd_r.dst};
    acc_we        = 1'b0;
    acc_waddr     = SAW'(e2_cmd_r.src);
    acc_wdata     = 1'b1;
    e3_has_nxt    = 1'b0;
    e3_kind_nxt   = RK_STATUS;
    e3_status_nxt = ST_OK;
    e3_took_nxt   = 1'b0;
    e3_emit_nxt   = 1'b0;
    e3_chars_nxt  = chars_r;
    if (clearing_r) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr_r;
      tbl_wdata = '0;
      acc_we    = (32'(clr_addr_r) < NUM_STATES);
      acc_waddr = SAW'(clr_addr_r);
      acc_wdata = 1'b0;
      if (clr_addr_r == TAW'(TD - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end else if (e2_v_r) begin
      unique case (e2_cmd_r.op)
        OP_WRITE: begin
          e3_has_nxt = 1'b1;
          if (e2_cmd_r.badch) begin
            e3_status_nxt = ST_BAD_CHAR;
          end else if (!st_ok(e2_cmd_r.src, states_in_use)) begin
            e3_status_nxt = ST_BAD_SRC;
          end else if (!st_ok(e2_cmd_r.dst, states_in_use)) begin
            e3_status_nxt = ST_BAD_DST;
          end else if (tbl_rdata[TW-1]) begin
            e3_status_nxt = ST_DUP;
          end else begin
            tbl_we = 1'b1;
          end
        end
        OP_MARK: begin
          e3_has_nxt = 1'b1;
          if (!st_ok(e2_cmd_r.src, states_in_use)) begin
            e3_status_nxt = ST_BAD_SRC;
          end else begin
            acc_we = 1'b1;
          end
        end
        OP_SCAN: begin
          if (dead_r) begin
            // skip the rest of a dead string up to its last character
            if (e2_cmd_r.last) begin
              dead_nxt = 1'b0;
            end
          end else if (e2_cmd_r.badch || (32'(dfa_state_r) >= NUM_STATES) ||
                       !tbl_rdata[TW-1]) begin
            e3_has_nxt    = 1'b1;
            e3_kind_nxt   = RK_MATCH;
            e3_emit_nxt   = 1'b1;
            dead_nxt      = !e2_cmd_r.last;
            dfa_state_nxt = '0;
            chars_nxt     = '0;
          end else begin
            e3_took_nxt   = 1'b1;
            e3_chars_nxt  = chars_inc;
            dfa_state_nxt = tbl_rdata[STATE_W-1:0];
            chars_nxt     = chars_inc;
            if (e2_cmd_r.last) begin
              e3_has_nxt    = 1'b1;
              e3_kind_nxt   = RK_MATCH;
              e3_emit_nxt   = 1'b1;
              dfa_state_nxt = '0;
              chars_nxt     = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stage 3
  always_comb begin
    best_new = best_r;
    seen_new = seen_r;
    if (e3_v_r && e3_took_r && acc_rdata) begin
      best_new = e3_chars_r;
      seen_new = 1'b1;
    end
    best_nxt = best_new;
    seen_nxt = seen_new;
    oq_push  = e3_v_r && e3_has_r;
    if (e3_kind_r == RK_MATCH) begin
      oq_data.result_kind  = RK_MATCH;
      oq_data.status       = ST_OK;
      oq_data.match_length = LEN_W'(best_new);
      oq_data.accepted     = seen_new;
    end else begin
      oq_data.result_kind  = RK_STATUS;
      oq_data.status       = e3_status_r;
      oq_data.match_length = '0;
      oq_data.accepted     = 1'b0;
    end
    if (e3_v_r && e3_emit_r) begin
      best_nxt = '0;
      seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      dfa_state_r <= '0;
      dead_r      <= 1'b0;
      chars_r     <= '0;
      best_r      <= '0;
      seen_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      e3_v_r      <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dfa_state_r <= dfa_state_nxt;
      dead_r      <= dead_nxt;
      chars_r     <= chars_nxt;
      best_r      <= best_nxt;
      seen_r      <= seen_nxt;
      e2_v_r      <= issue;
      e3_v_r      <= e2_v_r && !clearing_r;
    end
  end

  always_ff @(posedge clk) begin
    e2_cmd_r    <= q_cmd;
    e2_addr_r   <= rd_addr;
    e3_has_r    <= e3_has_nxt;
    e3_kind_r   <= e3_kind_nxt;
    e3_status_r <= e3_status_nxt;
    e3_took_r   <= e3_took_nxt;
    e3_emit_r   <= e3_emit_nxt;
    e3_chars_r  <= e3_chars_nxt;
  end

  // {valid, next state} per state and character
  dlpm_ram #(
    .WIDTH (TW),
    .DEPTH (TD)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (rd_addr),
    .rdata (tbl_rdata)
  );

  dlpm_ram #(
    .WIDTH (1),
    .DEPTH (NUM_STATES)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  dlpm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (oq_push),
    .push_ready (oq_push_ready),
    .push_data  (oq_data),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_item),
    .count      (oq_count)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> oq_push_ready)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !issue && !e2_v_r)
    else $error("item issued during clearing pass");

  assert property (@(posedge clk) disable iff (!rst_n)
    (e2_v_r && (e2_cmd_r.op == OP_WRITE)) |-> (!issue ##1 (e3_v_r && e3_has_r)))
    else $error("transition write lost its status or overlapped a table read");

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(dfa_state_r) < NUM_STATES)
    else $error("scan state beyond defined states");

endmodule

>>> rtl/core/dfa_longest_prefix_matcher.sv
// Top level of the table-driven DFA longest-prefix matcher.
// Depends on dlpm_pkg, dlpm_front and dlpm_back.
//
// Items on the in_ channel either write a transition (checked for bad
// character, bad source, bad destination and an entry already set, answered
// with a status item), mark a state accepting (status item) or scan one
// character of a string starting in state 0. A string ends on the character
// flagged is_last, on a bad character or on a missing transition; it then
// yields one match item with the longest accepted prefix length (saturating)
// and an accepted flag. After a bad character or missing transition, further
// characters are dropped up to the one flagged is_last. Scans and marks issue
// one per cycle while the result queue has room: the next-state table read
// feeds the following character's address, so the table memory's read port
// sets the rate. A transition write holds off the next item while it reads,
// checks and then writes its table entry on the same memory. A held out_
// channel fills the result queue, then the command queue, and then drops
// in_ready. After reset the table and accepting flags are swept clear over
// all NUM_STATES * ALPHABET_SIZE table entries, with in_ready low; cfg_
// writes to states_in_use are taken at any time and must only be issued
// while the block is idle.
module dfa_longest_prefix_matcher #(
  parameter int NUM_STATES    = dlpm_pkg::NUM_STATES_DEF,
  parameter int ALPHABET_SIZE = dlpm_pkg::ALPHABET_SIZE_DEF,
  parameter int LENGTH_BITS   = dlpm_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dlpm_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dlpm_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dlpm_pkg::SIU_W-1:0] cfg_data
);

  import dlpm_pkg::*;

  logic [SIU_W-1:0] states_in_use_r, states_in_use_nxt;
  logic             q_valid, q_ready;
  cmd_t             q_cmd;
  logic             clearing;

  // Configuration register: always ready, reset to a single state in use
  assign cfg_ready         = 1'b1;
  assign states_in_use_nxt = (cfg_valid && cfg_ready) ? cfg_data : states_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r <= SIU_W'(1);
    end else begin
      states_in_use_r <= states_in_use_nxt;
    end
  end

  // Front end: accept and classify items, queue them
  dlpm_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // Back end: run items against the table, advance the scan, queue results
  dlpm_back #(
    .NUM_STATES    (NUM_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .states_in_use (states_in_use_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_cmd         (q_cmd),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule
